// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion helpers, clocked on i_clk, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define DTLP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define DTLP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/dtlp_pkg.sv =====
// ----------------------------------------------------------------------------
// dtlp_pkg
// types, limits and helpers of the data object list tag/length parser
// ----------------------------------------------------------------------------
package dtlp_pkg;

    // longest tag and long-form length accepted without an oversize flag
    localparam int MAX_TAG_BYTES    = 4;
    localparam int MAX_LENGTH_BYTES = 4;

    localparam int TAG_CNT_W = 4;   // saturating tag byte counter, covers limits up to 14
    localparam int LEN_LEFT_W = 7;  // long-form byte count field

    localparam logic [TAG_CNT_W-1:0]  TAG_LIMIT = TAG_CNT_W'(MAX_TAG_BYTES);
    localparam logic [LEN_LEFT_W-1:0] LEN_LIMIT = LEN_LEFT_W'(MAX_LENGTH_BYTES);

    localparam logic [4:0] TAG_MULTI_MARK = 5'h1f;
    localparam logic [7:0] LEN_LONG_MARK  = 8'h80;

    typedef enum logic [1:0] {
        PH_TAG_FIRST,
        PH_TAG_MORE,
        PH_LEN_FIRST,
        PH_LEN_MORE
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TRUNC    = 2'd1,
        ST_OVERSIZE = 2'd2
    } t_status;

    typedef struct packed {
        t_phase                  phase;
        logic [31:0]             tag_accum;
        logic [TAG_CNT_W-1:0]    tag_count;
        logic [31:0]             len_accum;
        logic [LEN_LEFT_W-1:0]   len_left;
        logic [2:0]              len_field_sz;
        logic [15:0]             byte_pos;
        logic [15:0]             entry_start;
        logic [7:0]              entries_seen;
        logic [31:0]             size_sum;
        logic                    oversize;
    } t_state;

    typedef struct packed {
        logic [7:0]  entry_index;
        logic [15:0] entry_offset;
        logic [31:0] tag_value;
        logic [2:0]  tag_bytes;
        logic [31:0] data_length;
        logic [2:0]  length_bytes;
        logic [7:0]  entry_count;
        logic [31:0] size_total;
        t_status     status;
        logic        list_done;
    } t_result;

    function automatic t_state state_reset();
        t_state s;
        s.phase        = PH_TAG_FIRST;
        s.tag_accum    = '0;
        s.tag_count    = '0;
        s.len_accum    = '0;
        s.len_left     = '0;
        s.len_field_sz = '0;
        s.byte_pos     = '0;
        s.entry_start  = '0;
        s.entries_seen = '0;
        s.size_sum     = '0;
        s.oversize     = 1'b0;
        return s;
    endfunction

endpackage

// ===== rtl/dtlp_step.sv =====
// ----------------------------------------------------------------------------
// dtlp_step
// per-byte parse step: next parser state and the result a byte produces
// ----------------------------------------------------------------------------
module dtlp_step (
    input  dtlp_pkg::t_state  i_state,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output dtlp_pkg::t_state  o_state,
    output logic              o_res_valid,
    output dtlp_pkg::t_result o_res
);

    dtlp_pkg::t_state w_st;
    logic             w_done;
    logic [7:0]       w_len_sz;
    logic [32:0]      w_sum;

    always_comb begin
        w_st     = i_state;
        w_done   = 1'b0;
        w_len_sz = {1'b0, i_byte[6:0]} + 8'd1;
        w_sum    = '0;

        unique case (i_state.phase)
            dtlp_pkg::PH_TAG_FIRST: begin
                w_st.entry_start  = i_state.byte_pos;
                w_st.tag_accum    = {24'd0, i_byte};
                w_st.tag_count    = dtlp_pkg::TAG_CNT_W'(1);
                w_st.oversize     = 1'b0;
                w_st.len_accum    = '0;
                w_st.len_field_sz = '0;
                w_st.len_left     = '0;
                w_st.phase        = (i_byte[4:0] == dtlp_pkg::TAG_MULTI_MARK)
                                    ? dtlp_pkg::PH_TAG_MORE : dtlp_pkg::PH_LEN_FIRST;
            end
            dtlp_pkg::PH_TAG_MORE: begin
                w_st.tag_accum = {i_state.tag_accum[23:0], i_byte};
                if (i_state.tag_count != '1) begin
                    w_st.tag_count = i_state.tag_count + dtlp_pkg::TAG_CNT_W'(1);
                end
                if (w_st.tag_count > dtlp_pkg::TAG_LIMIT) begin
                    w_st.oversize = 1'b1;
                end
                if (!i_byte[7]) begin
                    w_st.phase = dtlp_pkg::PH_LEN_FIRST;
                end
            end
            dtlp_pkg::PH_LEN_FIRST: begin
                w_st.len_accum = '0;
                if (i_byte > dtlp_pkg::LEN_LONG_MARK) begin
                    // long form: low seven bits count the bytes that follow
                    w_st.len_field_sz = (w_len_sz > 8'd7) ? 3'd7 : w_len_sz[2:0];
                    w_st.len_left     = i_byte[6:0];
                    if (i_byte[6:0] > dtlp_pkg::LEN_LIMIT) begin
                        w_st.oversize = 1'b1;
                    end
                    w_st.phase = dtlp_pkg::PH_LEN_MORE;
                end else begin
                    w_st.len_field_sz = 3'd1;
                    w_st.len_accum    = i_byte[7] ? 32'd0 : {24'd0, i_byte};
                    w_done            = 1'b1;
                end
            end
            dtlp_pkg::PH_LEN_MORE: begin
                // saturate once another byte would overflow
                if (i_state.len_accum > 32'h00ff_ffff) begin
                    w_st.len_accum = '1;
                end else begin
                    w_st.len_accum = {i_state.len_accum[23:0], i_byte};
                end
                if (i_state.len_left != '0) begin
                    w_st.len_left = i_state.len_left - dtlp_pkg::LEN_LEFT_W'(1);
                end
                w_done = (w_st.len_left == '0);
            end
        endcase

        if (i_state.byte_pos != '1) begin
            w_st.byte_pos = i_state.byte_pos + 16'd1;
        end

        o_res.entry_index  = i_state.entries_seen;
        o_res.entry_offset = w_st.entry_start;
        o_res.tag_value    = w_st.tag_accum;
        o_res.tag_bytes    = (w_st.tag_count > dtlp_pkg::TAG_CNT_W'(7))
                             ? 3'd7 : w_st.tag_count[2:0];

        if (w_done) begin
            if (w_st.entries_seen != '1) begin
                w_st.entries_seen = w_st.entries_seen + 8'd1;
            end
            w_sum         = {1'b0, w_st.size_sum} + {1'b0, w_st.len_accum};
            w_st.size_sum = w_sum[32] ? 32'hffff_ffff : w_sum[31:0];
            w_st.phase    = dtlp_pkg::PH_TAG_FIRST;
            o_res.data_length  = w_st.len_accum;
            o_res.length_bytes = w_st.len_field_sz;
            o_res.status       = w_st.oversize ? dtlp_pkg::ST_OVERSIZE : dtlp_pkg::ST_OK;
        end else begin
            o_res.data_length  = '0;
            o_res.length_bytes = '0;
            o_res.status       = dtlp_pkg::ST_TRUNC;
        end

        o_res.entry_count = w_st.entries_seen;
        o_res.size_total  = w_st.size_sum;
        o_res.list_done   = i_last;
        o_res_valid       = w_done || i_last;

        // a closed list starts the next one from scratch
        o_state = i_last ? dtlp_pkg::state_reset() : w_st;
    end

endmodule

// ===== rtl/dol_tag_length_parser_core.sv =====
// ----------------------------------------------------------------------------
// dol_tag_length_parser_core
// streaming parser for data object lists (BER tag + BER length entries)
//
// input channel s_axis: one list byte per beat, tlast marks the final byte
// output channel m_axis: one beat per completed entry, plus one beat when the
//   list ends inside an entry (status truncated); tlast closes the list
// a result appears in the output register in the cycle after the byte that completes it
// throughput: one byte per cycle unless the output stalls; the parse step is a single
//   combinational pass from the parser state register to the output register
// s_axis_tready is low only while a result sits in the output register and
//   m_axis_tready is low; a stalled receiver holds off the input, no beat lost
// reset (synchronous, active low) empties the output register and returns
//   the parser to the start of a new list with all counters cleared
// after a tlast beat the parser clears itself and the next byte opens a list
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dol_tag_length_parser_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input byte stream
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] list_byte
    input  logic         s_axis_tlast,   // final_byte
    // entry result stream
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [7:0] entry_index, [23:8] entry_offset, [55:24] tag_value,
    // [58:56] tag_bytes, [90:59] data_length, [93:91] length_bytes,
    // [101:94] entry_count, [133:102] size_total, [135:134] zero
    output logic [135:0] m_axis_tdata,
    output logic [1:0]   m_axis_tuser,   // [1:0] status
    output logic         m_axis_tlast    // list_done
);

    dtlp_pkg::t_state  r_state;
    dtlp_pkg::t_state  n_state;
    dtlp_pkg::t_result r_res;
    dtlp_pkg::t_result step_res;
    logic              step_res_valid;
    logic              r_out_valid;
    logic              s_beat;

    // output register frees up in the same cycle it is drained
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_beat        = s_axis_tvalid && s_axis_tready;

    dtlp_step u_step (
        .i_state     (r_state),
        .i_byte      (s_axis_tdata),
        .i_last      (s_axis_tlast),
        .o_state     (n_state),
        .o_res_valid (step_res_valid),
        .o_res       (step_res)
    );

    // parser state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dtlp_pkg::state_reset();
            r_out_valid <= 1'b0;
        end else begin
            if (s_beat) begin
                r_state <= n_state;
            end
            if (s_beat && step_res_valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded only with a new result
    always_ff @(posedge i_clk) begin
        if (s_beat && step_res_valid) begin
            r_res <= step_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_res.size_total, r_res.entry_count, r_res.length_bytes,
                            r_res.data_length, r_res.tag_bytes, r_res.tag_value,
                            r_res.entry_offset, r_res.entry_index};
    assign m_axis_tuser  = 2'(r_res.status);
    assign m_axis_tlast  = r_res.list_done;

    // end of list must leave the parser cleared
    `DTLP_ASSERT_NEXT(a_list_end_clears, s_beat && s_axis_tlast, r_state.phase == dtlp_pkg::PH_TAG_FIRST && r_state.entries_seen == 8'd0 && r_state.byte_pos == 16'd0, "parser not cleared after end of list")

    // every final byte yields a closing result
    `DTLP_ASSERT_NEXT(a_last_gives_result, s_beat && s_axis_tlast, m_axis_tvalid && m_axis_tlast, "final byte produced no closing result")

    // a truncated entry only ever reports at the close of a list
    `DTLP_ASSERT(a_trunc_closes, !(m_axis_tvalid && m_axis_tuser == 2'(dtlp_pkg::ST_TRUNC)) || (m_axis_tlast && r_res.data_length == 32'd0 && r_res.length_bytes == 3'd0), "truncated result not at list end or with length")

endmodule
